[hw/rtl/tmcs_pkg.sv]
// Shared types, constants and helpers for the tile map collision step block.
`default_nettype none

package tmcs_pkg;

    // Internal datapath widths.
    localparam int POS_W   = 32;
    localparam int VY_W    = 26;
    localparam int TILE_W  = 24;
    localparam int PROD_W  = 52;
    localparam int MUL_W   = 26;
    localparam int FIELD_W = 24;
    localparam int DT_W    = 15;

    // Longest step time, 0.25 s in Q0.16.
    localparam logic [DT_W-1:0] STEP_CAP = 15'd16384;

    // Request types.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Axis being resolved.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Tile index slots filled by the divider.
    localparam logic [1:0] TSEL_PRI = 2'd0;
    localparam logic [1:0] TSEL_LO  = 2'd1;
    localparam logic [1:0] TSEL_HI  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd6;

    typedef struct packed {
        logic               req_type;
        logic [6:0]         tile_col;
        logic [6:0]         tile_row;
        logic               tile_solid;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [15:0]        step_time;
        logic               collidable;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] new_vel_x;
        logic signed [23:0] new_vel_y;
        logic               on_ground;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUB_START,
        ST_GRAV_MUL,
        ST_GRAV_ADD,
        ST_MOVX_MUL,
        ST_MOVX_ADD,
        ST_MOVY_MUL,
        ST_MOVY_ADD,
        ST_ARG,
        ST_DMUL,
        ST_DFIX,
        ST_PROBE,
        ST_PWAIT,
        ST_HIT,
        ST_COMMIT,
        ST_CLAMP_X,
        ST_CLAMP_Y,
        ST_DONE
    } state_t;

    // Saturate a wide signed value to the 24-bit result range.
    function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [POS_W-1:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v > 32'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -32'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tile_map_collision_step.sv]
// Top level of the tile map collision step block: tile store, sequencer and shared datapath.
`default_nettype none

// A load transaction writes one tile of the solid map and returns no result. A step
// transaction with nonzero time clamps the elapsed time to 0.25 s, cuts it into at most
// sub_step_limit sub-steps of at most sub_step_time each, and for every sub-step applies
// gravity, moves and resolves X, then moves and resolves Y against solid tiles (tiles
// outside the map in use are solid). A bounds clamp follows and one result transaction
// comes out. The time products and the divider's reciprocal product go through one shared
// 26x26 multiplier under a small sequencer, and the map is a single-port read memory, so
// the block takes one step transaction at a time and stalls its input until the result
// is loaded into its output register. An axis whose velocity is zero is not probed;
// otherwise the tiles on its leading edge are probed one by one, each through a
// registered read of the map. A non-collidable box runs one sub-step with no probing.
// After reset a clearing pass zeroes the map; input stays stalled during it while
// configuration writes are still taken.
module tile_map_collision_step #(
    parameter int TILE_PIXELS = 16,
    parameter int MAP_WIDTH   = 128,
    parameter int MAP_HEIGHT  = 128
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output      logic                                 in_stall,
    input  wire tmcs_pkg::in_item_t                   in_data,
    output      logic                                 out_valid,
    input  wire logic                                 out_stall,
    output      tmcs_pkg::out_item_t                  out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [tmcs_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [tmcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Map store geometry.
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAP_WIDTH + 1);
    localparam int RW    = $clog2(MAP_HEIGHT + 1);

    // One tile in Q.8 pixels, and the reciprocal of the tile size used by the
    // floor divider (exact after one correction step for 24-bit operands).
    localparam logic signed [tmcs_pkg::POS_W-1:0] TQ    = 32'(TILE_PIXELS * 256);
    localparam logic signed [tmcs_pkg::POS_W-1:0] TPX   = 32'(TILE_PIXELS);
    localparam logic [24:0]                       RECIP = 25'((1 << 24) / TILE_PIXELS);

    // Control state.
    tmcs_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Configuration registers.
    logic signed [23:0] grav_reg;
    logic signed [23:0] term_reg;
    logic [15:0]        sst_reg;
    logic [4:0]         lim_cfg_reg;
    logic [7:0]         skin_reg;
    logic [7:0]         cols_cfg_reg;
    logic [7:0]         rows_cfg_reg;

    // Working registers of one step transaction.
    logic signed [tmcs_pkg::POS_W-1:0]  x_reg, x_next;
    logic signed [tmcs_pkg::POS_W-1:0]  y_reg, y_next;
    logic signed [tmcs_pkg::POS_W-1:0]  npos_reg, npos_next;
    logic signed [tmcs_pkg::POS_W-1:0]  arg_reg, arg_next;
    logic [15:0]                        w_reg, w_next;
    logic [15:0]                        h_reg, h_next;
    logic signed [23:0]                 vx_reg, vx_next;
    logic signed [tmcs_pkg::VY_W-1:0]   vy_reg, vy_next;
    logic [tmcs_pkg::DT_W-1:0]          rem_reg, rem_next;
    logic [tmcs_pkg::DT_W-1:0]          st_reg, st_next;
    logic [15:0]                        maxstep_reg, maxstep_next;
    logic [4:0]                         limit_reg, limit_next;
    logic [4:0]                         n_reg, n_next;
    logic                               nocol_reg, nocol_next;
    logic                               ground_reg, ground_next;
    logic                               axis_reg, axis_next;
    logic [1:0]                         k_reg, k_next;
    logic signed [tmcs_pkg::TILE_W-1:0] tpri_reg, tpri_next;
    logic signed [tmcs_pkg::TILE_W-1:0] tlo_reg, tlo_next;
    logic signed [tmcs_pkg::TILE_W-1:0] thi_reg, thi_next;
    logic signed [tmcs_pkg::TILE_W-1:0] scan_reg, scan_next;
    logic signed [tmcs_pkg::PROD_W-1:0] prod_reg;
    tmcs_pkg::out_item_t                out_reg, out_next;

    // Map memory.
    logic          mem [DEPTH];
    logic          mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] rd_addr;

    // Shared multiplier.
    logic signed [tmcs_pkg::MUL_W-1:0]  mul_a;
    logic signed [tmcs_pkg::MUL_W-1:0]  mul_b;
    logic signed [tmcs_pkg::PROD_W-1:0] mul_p;

    // Helper values.
    logic                               in_acc;
    logic                               load_wr;
    logic                               out_free;
    logic [15:0]                        cols16;
    logic [15:0]                        rows16;
    logic [CW-1:0]                      cols_eff;
    logic [RW-1:0]                      rows_eff;
    logic signed [tmcs_pkg::POS_W-1:0]  w32;
    logic signed [tmcs_pkg::POS_W-1:0]  h32;
    logic signed [tmcs_pkg::POS_W-1:0]  e32;
    logic signed [tmcs_pkg::POS_W-1:0]  pshift;
    logic signed [tmcs_pkg::VY_W-1:0]   gterm;
    logic signed [tmcs_pkg::VY_W-1:0]   vsum;
    logic signed [tmcs_pkg::VY_W-1:0]   term26;
    logic                               sub_go;
    logic [tmcs_pkg::DT_W-1:0]          st_val;
    logic signed [tmcs_pkg::POS_W-1:0]  arg_val;
    logic signed [tmcs_pkg::TILE_W-1:0] div_a;
    logic signed [tmcs_pkg::TILE_W-1:0] div_q0;
    logic signed [tmcs_pkg::POS_W-1:0]  div_r;
    logic signed [tmcs_pkg::TILE_W-1:0] div_q;
    logic signed [tmcs_pkg::TILE_W-1:0] ptx;
    logic signed [tmcs_pkg::TILE_W-1:0] pty;
    logic                               oob;
    logic                               scan_end;
    logic signed [tmcs_pkg::POS_W-1:0]  tbase;
    logic signed [tmcs_pkg::POS_W-1:0]  hit_pos;
    logic signed [tmcs_pkg::POS_W-1:0]  maxx;
    logic signed [tmcs_pkg::POS_W-1:0]  maxy;
    logic                               x_lo;
    logic                               x_hi;
    logic signed [tmcs_pkg::POS_W-1:0]  x_c1;
    logic                               y_lo;
    logic                               y_hi;
    logic signed [tmcs_pkg::POS_W-1:0]  y_c1;
    logic [tmcs_pkg::DT_W-1:0]          dt_cap;
    logic [15:0]                        sst_eff;

    assign in_stall  = (state_reg != tmcs_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // A load outside the store is dropped.
    assign load_wr = in_acc && (in_data.req_type == tmcs_pkg::REQ_LOAD)
                     && (32'(in_data.tile_col) < MAP_WIDTH)
                     && (32'(in_data.tile_row) < MAP_HEIGHT);

    // Map size in use, limited to the store.
    assign cols16   = ({8'd0, cols_cfg_reg} > 16'(MAP_WIDTH)) ? 16'(MAP_WIDTH)
                                                               : {8'd0, cols_cfg_reg};
    assign rows16   = ({8'd0, rows_cfg_reg} > 16'(MAP_HEIGHT)) ? 16'(MAP_HEIGHT)
                                                                : {8'd0, rows_cfg_reg};
    assign cols_eff = cols16[CW-1:0];
    assign rows_eff = rows16[RW-1:0];

    assign w32 = $signed(32'(w_reg));
    assign h32 = $signed(32'(h_reg));
    assign e32 = $signed(32'(skin_reg));

    // Floor of a Q0.16 product is an arithmetic shift.
    assign pshift = $signed(prod_reg[47:16]);
    assign gterm  = $signed(prod_reg[41:16]);
    assign term26 = tmcs_pkg::VY_W'(term_reg);
    assign vsum   = vy_reg + gterm;

    // Sub-step scheduling.
    assign sub_go = (n_reg < limit_reg) && (rem_reg != '0);
    assign st_val = ({1'b0, rem_reg} < maxstep_reg) ? rem_reg : maxstep_reg[tmcs_pkg::DT_W-1:0];

    assign dt_cap  = (in_data.step_time > 16'(tmcs_pkg::STEP_CAP)) ? tmcs_pkg::STEP_CAP
                                                         : in_data.step_time[tmcs_pkg::DT_W-1:0];
    assign sst_eff = (sst_reg == '0) ? 16'd1 : sst_reg;

    // Operand for the floor divider: the leading edge first, then the two ends of the
    // span across the other axis.
    always_comb
    begin
        if (axis_reg == tmcs_pkg::AXIS_X)
        begin
            case (k_reg)
                tmcs_pkg::TSEL_PRI: arg_val = (vx_reg > 0) ? npos_reg + w32 - e32
                                                           : npos_reg + e32;
                tmcs_pkg::TSEL_LO:  arg_val = y_reg + e32;
                default:            arg_val = y_reg + h32 - e32;
            endcase
        end
        else
        begin
            case (k_reg)
                tmcs_pkg::TSEL_PRI: arg_val = (vy_reg > 0) ? npos_reg + h32 - e32
                                                           : npos_reg + e32;
                tmcs_pkg::TSEL_LO:  arg_val = x_reg + e32;
                default:            arg_val = x_reg + w32 - e32;
            endcase
        end
    end

    // Floor division by the tile size: reciprocal estimate plus one correction.
    assign div_a  = $signed(arg_reg[31:8]);
    assign div_q0 = $signed(prod_reg[47:24]);
    assign div_r  = 32'(div_a) - 32'(32'(div_q0) * TPX);
    assign div_q  = (div_r < 0) ? div_q0 - 24'sd1 :
                    (div_r >= TPX) ? div_q0 + 24'sd1 : div_q0;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            tmcs_pkg::ST_GRAV_MUL:
            begin
                mul_a = tmcs_pkg::MUL_W'(grav_reg);
                mul_b = $signed(tmcs_pkg::MUL_W'(st_reg));
            end
            tmcs_pkg::ST_MOVX_MUL:
            begin
                mul_a = tmcs_pkg::MUL_W'(vx_reg);
                mul_b = $signed(tmcs_pkg::MUL_W'(st_reg));
            end
            tmcs_pkg::ST_MOVY_MUL:
            begin
                mul_a = vy_reg;
                mul_b = $signed(tmcs_pkg::MUL_W'(st_reg));
            end
            default:
            begin
                mul_a = tmcs_pkg::MUL_W'(div_a);
                mul_b = $signed(tmcs_pkg::MUL_W'(RECIP));
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Tile being probed; the scan runs along the span of the other axis.
    assign ptx      = (axis_reg == tmcs_pkg::AXIS_X) ? tpri_reg : scan_reg;
    assign pty      = (axis_reg == tmcs_pkg::AXIS_X) ? scan_reg : tpri_reg;
    assign oob      = ptx[tmcs_pkg::TILE_W-1] || pty[tmcs_pkg::TILE_W-1]
                      || (ptx >= $signed(tmcs_pkg::TILE_W'(cols_eff)))
                      || (pty >= $signed(tmcs_pkg::TILE_W'(rows_eff)));
    assign scan_end = (scan_reg > thi_reg);
    assign rd_addr  = AW'(32'(pty) * MAP_WIDTH + 32'(ptx));

    // Contact position: flush against the near face of the solid tile.
    assign tbase   = 32'(32'(tpri_reg) * TQ);
    assign hit_pos = (axis_reg == tmcs_pkg::AXIS_X)
                     ? ((vx_reg > 0) ? tbase - w32 : tbase + TQ)
                     : ((vy_reg > 0) ? tbase - h32 : tbase + TQ);

    // World bounds clamp.
    assign maxx = 32'($signed(32'(cols_eff)) * TQ) - w32;
    assign maxy = 32'($signed(32'(rows_eff)) * TQ) - h32;
    assign x_lo = (x_reg < 0);
    assign x_c1 = x_lo ? '0 : x_reg;
    assign x_hi = (x_c1 > maxx);
    assign y_lo = (y_reg < 0);
    assign y_c1 = y_lo ? '0 : y_reg;
    assign y_hi = (y_c1 > maxy);

    // Map memory: clearing pass or load write, one registered read.
    assign mem_we    = (state_reg == tmcs_pkg::ST_CLEAR) || load_wr;
    assign mem_waddr = (state_reg == tmcs_pkg::ST_CLEAR) ? clr_cnt_reg
                       : AW'(32'(in_data.tile_row) * MAP_WIDTH + 32'(in_data.tile_col));
    assign mem_wdata = (state_reg == tmcs_pkg::ST_CLEAR) ? 1'b0 : in_data.tile_solid;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmcs_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = tmcs_pkg::ST_IDLE;
                end
            end
            tmcs_pkg::ST_IDLE:
            begin
                if (in_acc && (in_data.req_type == tmcs_pkg::REQ_STEP)
                    && (in_data.step_time != '0))
                begin
                    state_next = tmcs_pkg::ST_SUB_START;
                end
            end
            tmcs_pkg::ST_SUB_START:
            begin
                state_next = sub_go ? tmcs_pkg::ST_GRAV_MUL : tmcs_pkg::ST_CLAMP_X;
            end
            tmcs_pkg::ST_GRAV_MUL: state_next = tmcs_pkg::ST_GRAV_ADD;
            tmcs_pkg::ST_GRAV_ADD: state_next = tmcs_pkg::ST_MOVX_MUL;
            tmcs_pkg::ST_MOVX_MUL: state_next = tmcs_pkg::ST_MOVX_ADD;
            tmcs_pkg::ST_MOVX_ADD:
            begin
                state_next = (nocol_reg || vx_reg == '0) ? tmcs_pkg::ST_COMMIT
                                                         : tmcs_pkg::ST_ARG;
            end
            tmcs_pkg::ST_MOVY_MUL: state_next = tmcs_pkg::ST_MOVY_ADD;
            tmcs_pkg::ST_MOVY_ADD:
            begin
                state_next = (nocol_reg || vy_reg == '0) ? tmcs_pkg::ST_COMMIT
                                                         : tmcs_pkg::ST_ARG;
            end
            tmcs_pkg::ST_ARG:  state_next = tmcs_pkg::ST_DMUL;
            tmcs_pkg::ST_DMUL: state_next = tmcs_pkg::ST_DFIX;
            tmcs_pkg::ST_DFIX:
            begin
                state_next = (k_reg == tmcs_pkg::TSEL_HI) ? tmcs_pkg::ST_PROBE
                                                          : tmcs_pkg::ST_ARG;
            end
            tmcs_pkg::ST_PROBE:
            begin
                if (scan_end)
                begin
                    state_next = tmcs_pkg::ST_COMMIT;
                end
                else if (oob)
                begin
                    state_next = tmcs_pkg::ST_HIT;
                end
                else
                begin
                    state_next = tmcs_pkg::ST_PWAIT;
                end
            end
            tmcs_pkg::ST_PWAIT:
            begin
                state_next = mem_q_reg ? tmcs_pkg::ST_HIT : tmcs_pkg::ST_PROBE;
            end
            tmcs_pkg::ST_HIT: state_next = tmcs_pkg::ST_COMMIT;
            tmcs_pkg::ST_COMMIT:
            begin
                state_next = (axis_reg == tmcs_pkg::AXIS_X) ? tmcs_pkg::ST_MOVY_MUL
                                                            : tmcs_pkg::ST_SUB_START;
            end
            tmcs_pkg::ST_CLAMP_X: state_next = tmcs_pkg::ST_CLAMP_Y;
            tmcs_pkg::ST_CLAMP_Y: state_next = tmcs_pkg::ST_DONE;
            tmcs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tmcs_pkg::ST_IDLE;
                end
            end
            default: state_next = tmcs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output updates.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        npos_next      = npos_reg;
        arg_next       = arg_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        rem_next       = rem_reg;
        st_next        = st_reg;
        maxstep_next   = maxstep_reg;
        limit_next     = limit_reg;
        n_next         = n_reg;
        nocol_next     = nocol_reg;
        ground_next    = ground_reg;
        axis_next      = axis_reg;
        k_next         = k_reg;
        tpri_next      = tpri_reg;
        tlo_next       = tlo_reg;
        thi_next       = thi_reg;
        scan_next      = scan_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tmcs_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            tmcs_pkg::ST_IDLE:
            begin
                x_next      = tmcs_pkg::POS_W'(in_data.pos_x);
                y_next      = tmcs_pkg::POS_W'(in_data.pos_y);
                w_next      = in_data.box_width;
                h_next      = in_data.box_height;
                vx_next     = in_data.vel_x;
                vy_next     = tmcs_pkg::VY_W'(in_data.vel_y);
                rem_next    = dt_cap;
                n_next      = '0;
                ground_next = 1'b0;
                nocol_next  = !in_data.collidable;
                // A non-collidable box runs one whole sub-step without probing.
                if (in_data.collidable)
                begin
                    maxstep_next = sst_eff;
                    limit_next   = (lim_cfg_reg > 5'd16) ? 5'd16 : lim_cfg_reg;
                end
                else
                begin
                    maxstep_next = 16'(tmcs_pkg::STEP_CAP);
                    limit_next   = 5'd1;
                end
            end
            tmcs_pkg::ST_SUB_START:
            begin
                st_next   = st_val;
                rem_next  = rem_reg - st_val;
                axis_next = tmcs_pkg::AXIS_X;
            end
            tmcs_pkg::ST_GRAV_ADD:
            begin
                vy_next = (vsum > term26) ? term26 : vsum;
            end
            tmcs_pkg::ST_MOVX_ADD:
            begin
                npos_next = x_reg + pshift;
                k_next    = tmcs_pkg::TSEL_PRI;
            end
            tmcs_pkg::ST_MOVY_ADD:
            begin
                npos_next = y_reg + pshift;
                k_next    = tmcs_pkg::TSEL_PRI;
            end
            tmcs_pkg::ST_ARG:
            begin
                arg_next = arg_val;
            end
            tmcs_pkg::ST_DFIX:
            begin
                case (k_reg)
                    tmcs_pkg::TSEL_PRI: tpri_next = div_q;
                    tmcs_pkg::TSEL_LO:  tlo_next  = div_q;
                    default:            thi_next  = div_q;
                endcase
                if (k_reg == tmcs_pkg::TSEL_HI)
                begin
                    scan_next = tlo_reg;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            tmcs_pkg::ST_PWAIT:
            begin
                if (!mem_q_reg)
                begin
                    scan_next = scan_reg + 24'sd1;
                end
            end
            tmcs_pkg::ST_HIT:
            begin
                npos_next = hit_pos;
                if (axis_reg == tmcs_pkg::AXIS_X)
                begin
                    vx_next = '0;
                end
                else
                begin
                    if (vy_reg > 0)
                    begin
                        ground_next = 1'b1;
                    end
                    vy_next = '0;
                end
            end
            tmcs_pkg::ST_COMMIT:
            begin
                if (axis_reg == tmcs_pkg::AXIS_X)
                begin
                    x_next    = npos_reg;
                    axis_next = tmcs_pkg::AXIS_Y;
                end
                else
                begin
                    y_next    = npos_reg;
                    n_next    = n_reg + 5'd1;
                    axis_next = tmcs_pkg::AXIS_X;
                end
            end
            tmcs_pkg::ST_CLAMP_X:
            begin
                x_next = x_hi ? maxx : x_c1;
                if (x_lo || x_hi)
                begin
                    vx_next = '0;
                end
            end
            tmcs_pkg::ST_CLAMP_Y:
            begin
                y_next = y_hi ? maxy : y_c1;
                if (y_lo || y_hi)
                begin
                    vy_next = '0;
                end
                if (y_hi)
                begin
                    ground_next = 1'b1;
                end
            end
            tmcs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.new_pos_x = tmcs_pkg::sat_field(x_reg);
                    out_next.new_pos_y = tmcs_pkg::sat_field(y_reg);
                    out_next.new_vel_x = vx_reg;
                    out_next.new_vel_y = tmcs_pkg::sat_field(tmcs_pkg::POS_W'(vy_reg));
                    out_next.on_ground = ground_reg;
                    out_valid_next     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmcs_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg     <= 24'sd460800;
            term_reg     <= 24'sd256000;
            sst_reg      <= 16'd546;
            lim_cfg_reg  <= 5'd8;
            skin_reg     <= 8'd3;
            cols_cfg_reg <= 8'd128;
            rows_cfg_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tmcs_pkg::CFG_GRAVITY:  grav_reg     <= $signed(cfg_data);
                tmcs_pkg::CFG_TERMINAL: term_reg     <= $signed(cfg_data);
                tmcs_pkg::CFG_SUB_TIME: sst_reg      <= cfg_data[15:0];
                tmcs_pkg::CFG_SUB_LIM:  lim_cfg_reg  <= cfg_data[4:0];
                tmcs_pkg::CFG_SKIN:     skin_reg     <= cfg_data[7:0];
                tmcs_pkg::CFG_COLS:     cols_cfg_reg <= cfg_data[7:0];
                tmcs_pkg::CFG_ROWS:     rows_cfg_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        npos_reg    <= npos_next;
        arg_reg     <= arg_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        rem_reg     <= rem_next;
        st_reg      <= st_next;
        maxstep_reg <= maxstep_next;
        limit_reg   <= limit_next;
        n_reg       <= n_next;
        nocol_reg   <= nocol_next;
        ground_reg  <= ground_next;
        axis_reg    <= axis_next;
        k_reg       <= k_next;
        tpri_reg    <= tpri_next;
        tlo_reg     <= tlo_next;
        thi_reg     <= thi_next;
        scan_reg    <= scan_next;
        prod_reg    <= mul_p;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

[hw/rtl/tmcs_checker.sv]
// Port-level checker for the tile map collision step block and its bind.
`default_nettype none

module tmcs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire tmcs_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire tmcs_pkg::out_item_t out_data
);

    // The map is being cleared right after reset, so no transaction may enter.
    a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
        else $error("input not stalled after reset");

    // A step with nonzero time keeps the block busy in the next cycle.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.req_type == tmcs_pkg::REQ_STEP
         && in_data.step_time != '0) |=> in_stall)
        else $error("block ready right after a step transaction");

    // A load or a zero-time step leaves the block ready in the next cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_data.req_type == tmcs_pkg::REQ_LOAD
         || in_data.step_time == '0)) |=> !in_stall)
        else $error("block busy after a load or zero-time step");

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind tile_map_collision_step tmcs_checker u_tmcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
